FILE: design/pcm_sample_to_float32_core_macros.svh
// assertion macros for the pcm to float32 converter
`ifndef PCM_SAMPLE_TO_FLOAT32_CORE_MACROS_SVH
`define PCM_SAMPLE_TO_FLOAT32_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PCM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PCM_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PCM_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define PCM_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: design/pcm2f_pkg.sv
// types and constants for the pcm to float32 converter
package pcm2f_pkg;
	typedef enum logic [2:0] {
		DEPTH_U8  = 3'd0,
		DEPTH_S16 = 3'd1,
		DEPTH_S24 = 3'd2,
		DEPTH_S32 = 3'd3,
		DEPTH_F64 = 3'd4
	} depth_t;

	localparam logic [2:0] DEPTH_RESET = 3'd1;
	localparam logic [31:0] F32_INF = 32'h7F80_0000;
	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
	localparam int unsigned REG_DEPTH = 0;

	typedef struct packed {
		logic [63:0] raw_sample;
		logic        last_sample;
	} in_item_t;

	typedef struct packed {
		logic [31:0] float_bits;
		logic        last_out;
	} out_item_t;
endpackage

FILE: design/pcm_sample_to_float32_core.sv
// Converts one PCM sample (u8, s16, s24, s32 or float64) per cycle into its binary32 bit
// pattern. Four register stages: decode, leading-one search, alignment shift, rounding and
// packing. Each accepted item passes through the stage 1, stage 2 and stage 3 registers and
// the output register before out_valid rises. The pipeline accepts an item every cycle;
// only a low out_ready stalls it, and a stall loses nothing. The depth register sits at
// address 0 of the configuration port and resets to signed 16-bit.
module pcm_sample_to_float32_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pcm2f_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pcm2f_pkg::out_item_t  out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import pcm2f_pkg::*;
	`include "pcm_sample_to_float32_core_macros.svh"

	logic [2:0] depth_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr[1:0] == 2'(REG_DEPTH * 4));
	assign prdata = (paddr == 2'(REG_DEPTH * 4)) ? {29'd0, depth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (wr_en) begin
			depth_q <= pwdata[2:0];
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: decode into sign, magnitude and base exponent, or a finished special value
	logic        sign_c, spec_c, f64_c;
	logic [52:0] mag_c;
	logic [31:0] spec_bits_c;
	logic signed [11:0] bexp_c;

	logic [63:0] raw;
	logic [10:0] ex;
	logic [51:0] frac;
	logic [31:0] ival;
	logic        ineg;
	assign raw = in_data.raw_sample;
	assign ex = raw[62:52];
	assign frac = raw[51:0];

	always_comb begin
		sign_c = 1'b0;
		spec_c = 1'b0;
		f64_c = 1'b0;
		mag_c = '0;
		spec_bits_c = '0;
		bexp_c = '0;
		ival = '0;
		ineg = 1'b0;
		case (depth_q)
			DEPTH_U8: begin
				ival = {{24{~raw[7]}}, ~raw[7], raw[6:0]};
				bexp_c = -12'sd7;
			end
			DEPTH_S16: begin
				ival = {{16{raw[15]}}, raw[15:0]};
				bexp_c = -12'sd15;
			end
			DEPTH_S24: begin
				ival = {{8{raw[23]}}, raw[23:0]};
				bexp_c = -12'sd23;
			end
			DEPTH_S32: begin
				ival = raw[31:0];
				bexp_c = -12'sd31;
			end
			DEPTH_F64: begin
				f64_c = 1'b1;
				sign_c = raw[63];
				mag_c = {1'b1, frac};
				// value = mag * 2^(ex-1023-52)
				bexp_c = $signed({1'b0, ex}) - 12'sd1075;
				if (ex == 11'h7FF) begin
					spec_c = 1'b1;
					spec_bits_c = (frac == '0) ? {raw[63], F32_INF[30:0]}
						: {raw[63], F32_QNAN[30:0]} | {9'd0, frac[51:29]};
				end else if (ex == 11'd0) begin
					spec_c = 1'b1;
					spec_bits_c = {raw[63], 31'd0};
				end
			end
			default: begin
				spec_c = 1'b1;
				spec_bits_c = '0;
			end
		endcase
		if (!f64_c && !spec_c) begin
			ineg = ival[31];
			sign_c = ineg;
			mag_c = {21'd0, ineg ? (32'd0 - ival) : ival};
			if (ival == '0) begin
				spec_c = 1'b1;
				spec_bits_c = '0;
			end
		end
	end

	logic        sign_s1, spec_s1;
	logic [52:0] mag_s1;
	logic [31:0] spec_bits_s1;
	logic signed [11:0] bexp_s1;
	logic        last_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			sign_s1 <= sign_c;
			spec_s1 <= spec_c;
			mag_s1 <= mag_c;
			spec_bits_s1 <= spec_bits_c;
			bexp_s1 <= bexp_c;
			last_s1 <= in_data.last_sample;
		end
	end

	// stage 2: leading-one position
	logic [5:0] p_c;
	always_comb begin
		p_c = '0;
		for (int i = 0; i < 53; i++) begin
			if (mag_s1[i]) p_c = 6'(i);
		end
	end

	logic        sign_s2, spec_s2, last_s2;
	logic [52:0] mag_s2;
	logic [31:0] spec_bits_s2;
	logic [5:0]  p_s2;
	logic signed [11:0] e_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			sign_s2 <= sign_s1;
			spec_s2 <= spec_s1;
			last_s2 <= last_s1;
			mag_s2 <= mag_s1;
			spec_bits_s2 <= spec_bits_s1;
			p_s2 <= p_c;
			// biased exponent of the leading one
			e_s2 <= bexp_s1 + $signed({6'd0, p_c}) + 12'sd127;
		end
	end

	// stage 3: align to a 24-bit significand plus guard and sticky, with subnormal shift
	logic [11:0]  dsub_c;
	logic [6:0]   sh_c;
	logic [148:0] ext_c;
	logic [24:0]  top_c;
	logic         sticky_c;
	logic         sub_c;
	always_comb begin
		sub_c = (e_s2 < 12'sd1);
		// extra right shift below the normal range
		dsub_c = 12'd1 - 12'(e_s2);
		if (!sub_c) sh_c = 7'(p_s2);
		else if (e_s2 < -12'sd40) sh_c = 7'd127;
		else sh_c = 7'(p_s2) + dsub_c[6:0];
		// leading one lands on bit 96 when normal, guard at bit 72
		ext_c = {mag_s2, 96'd0} >> sh_c;
		top_c = ext_c[96:72];
		sticky_c = |ext_c[71:0];
	end

	logic        sign_s3, spec_s3, last_s3, sub_s3, sticky_s3;
	logic [24:0] top_s3;
	logic [31:0] spec_bits_s3;
	logic signed [11:0] e_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			sign_s3 <= sign_s2;
			spec_s3 <= spec_s2;
			last_s3 <= last_s2;
			sub_s3 <= sub_c;
			sticky_s3 <= sticky_c;
			top_s3 <= top_c;
			spec_bits_s3 <= spec_bits_s2;
			e_s3 <= e_s2;
		end
	end

	// stage 4: round to nearest even and pack
	logic [23:0] keep_c;
	logic [24:0] rnd_c;
	logic [11:0] ef_c;
	logic [31:0] bits_c;
	always_comb begin
		ef_c = '0;
		keep_c = top_s3[24:1];
		rnd_c = {1'b0, keep_c};
		if (top_s3[0] && (sticky_s3 || keep_c[0])) rnd_c = rnd_c + 25'd1;
		if (sub_s3) begin
			// carry into bit 23 gives the smallest normal
			bits_c = {sign_s3, 8'd0, 23'd0} | {8'd0, rnd_c[23:0]};
		end else begin
			ef_c = 12'(e_s3) + (rnd_c[24] ? 12'd1 : 12'd0);
			if ($signed(ef_c) >= 12'sd255) bits_c = {sign_s3, F32_INF[30:0]};
			else bits_c = {sign_s3, ef_c[7:0],
				rnd_c[24] ? rnd_c[23:1] : rnd_c[22:0]};
		end
		if (spec_s3) bits_c = spec_bits_s3;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			out_data.float_bits <= bits_c;
			out_data.last_out <= last_s3;
		end
	end
	assign out_valid = v_s4;

	`PCM_ASSERT_CLK(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped")
	`PCM_ASSERT_CLK(a_ready, clk, arst_n, !out_valid |-> in_ready, "empty pipe stalls")
	`PCM_ASSERT_RST(a_rst, clk, !arst_n |-> !out_valid, "valid during reset")
endmodule
